// ===== sv/fat_cluster_chain_allocator_assert.svh =====
// Assertion macros for the cluster chain allocator.
`ifndef FAT_CLUSTER_CHAIN_ALLOCATOR_ASSERT_SVH
`define FAT_CLUSTER_CHAIN_ALLOCATOR_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle property, checked at every rising clock edge outside reset.
`define FCCA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Antecedent in one cycle, consequent in the next.
`define FCCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FCCA_ASSERT(label, clk, rst, prop, msg)
`define FCCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== sv/fcca_pkg.sv =====
// Shared types and constants of the cluster chain allocator.
`default_nettype none
package fcca_pkg;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NEXT  = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BROKEN = 2'd2;

  localparam logic       REG_LIMIT = 1'b0;
  localparam logic       REG_SHIFT = 1'b1;

  localparam logic [31:0] END_MARK    = 32'hFFFF_FFFF;
  localparam logic [31:0] MEDIA_MARK  = 32'hFFFF_FFF8;
  localparam logic [12:0] FIRST_DATA  = 13'd2;
  localparam logic [12:0] COUNT_MAX   = 13'h1FFF;
  localparam logic [12:0] MIN_LIMIT   = 13'd3;
  localparam logic [12:0] RESET_LIMIT = 13'd4096;
  localparam logic [3:0]  MIN_SHIFT   = 4'd9;
  localparam logic [3:0]  RESET_SHIFT = 4'd12;

  // Effective configuration, already clamped to its legal range.
  typedef struct packed {
    logic [12:0] limit;
    logic [3:0]  shift;
  } cfg_t;

endpackage
`default_nettype wire

// ===== sv/fcca_if.sv =====
// Valid/ready channel interfaces for commands and results.
`default_nettype none
interface fcca_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] cluster_number;
  logic [31:0] byte_length;
  logic        extend;

  modport source (output valid, output command, output cluster_number,
                  output byte_length, output extend, input ready);
  modport sink   (input valid, input command, input cluster_number,
                  input byte_length, input extend, output ready);
endinterface

interface fcca_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_cluster;
  logic [1:0]  status;
  logic [12:0] free_count;
  logic [12:0] next_free_hint;

  modport source (output valid, output result_cluster, output status,
                  output free_count, output next_free_hint, input ready);
  modport sink   (input valid, input result_cluster, input status,
                  input free_count, input next_free_hint, output ready);
endinterface
`default_nettype wire

// ===== sv/fcca_table_ram.sv =====
// Allocation table memory: one write port, one registered read port.
`default_nettype none
module fcca_table_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/fcca_apb_regs.sv =====
// APB configuration registers with clamping to the legal ranges.
`default_nettype none
module fcca_apb_regs #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output fcca_pkg::cfg_t   cfg
);
  import fcca_pkg::*;

  localparam logic [31:0] ENTRIES32 = 32'(TABLE_ENTRIES);

  logic [12:0] cluster_limit;
  logic [3:0]  cluster_shift;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_limit <= RESET_LIMIT;
      cluster_shift <= RESET_SHIFT;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_LIMIT: cluster_limit <= pwdata[12:0];
        REG_SHIFT: cluster_shift <= pwdata[3:0];
        default:   cluster_limit <= cluster_limit;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LIMIT: prdata = {19'd0, cluster_limit};
      REG_SHIFT: prdata = {28'd0, cluster_shift};
      default:   prdata = 32'd0;
    endcase
  end

  // The limit is held to 3..TABLE_ENTRIES and the shift to at least 9.
  always_comb begin
    if ({19'd0, cluster_limit} > ENTRIES32) begin
      cfg.limit = 13'(TABLE_ENTRIES);
    end else if (cluster_limit < MIN_LIMIT) begin
      cfg.limit = MIN_LIMIT;
    end else begin
      cfg.limit = cluster_limit;
    end
    cfg.shift = (cluster_shift < MIN_SHIFT) ? MIN_SHIFT : cluster_shift;
  end

endmodule
`default_nettype wire

// ===== sv/fat_cluster_chain_allocator.sv =====
// Top level of the FAT32-style cluster chain allocator.
//
//   Channel  Kind             Direction  Carries
//   req      valid/ready      in         command, cluster_number, byte_length, extend
//   rsp      valid/ready      out        result_cluster, status, free_count, next_free_hint
//   apb      APB, pready = 1  in/out     cluster_limit (0x0), cluster_shift (0x4)
//
// Every table access goes through the table memory's write port and registered
// read port, one read and one write per cycle, under a small sequencer. Init
// sweeps every table entry, then loads the result. Allocation issues a read
// and probes entries for each cluster, links each later one, then loads the result.
// Free reads and checks each cluster walked; next link reads the entry and loads
// the result, or extends the chain. After reset a clearing pass over every entry
// runs before the first command transfer. A stalled result holds in the output
// register while the next command is already taken.
`default_nettype none
`include "fat_cluster_chain_allocator_assert.svh"
module fat_cluster_chain_allocator #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  fcca_cmd_if.sink         req,
  fcca_rsp_if.source       rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import fcca_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);
  // The free count after reset is the reset limit clamped to the table size.
  localparam logic [12:0] RESET_FREE =
    (TABLE_ENTRIES < 4096) ? 13'(TABLE_ENTRIES) : RESET_LIMIT;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_CLEAR    = 9'b000000010,
    S_SCAN_RD  = 9'b000000100,
    S_SCAN_CHK = 9'b000001000,
    S_LINK     = 9'b000010000,
    S_WALK_RD  = 9'b000100000,
    S_WALK_CHK = 9'b001000000,
    S_NEXT_CHK = 9'b010000000,
    S_OUT      = 9'b100000000
  } state_t;

  cfg_t cfg;

  fcca_apb_regs #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   rdata;

  fcca_table_ram #(.DEPTH(TABLE_ENTRIES), .AW(AW)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  state_t      state;
  logic [AW-1:0] clr_addr;
  logic        sweep_reply;   // the sweep was started by an init command
  logic        ext_mode;      // the current scan extends a chain
  logic        linking;       // the first cluster of the chain is already taken
  logic        rollback;      // the walk releases a failed partial chain
  logic        ext_req;
  logic [31:0] walk_c;
  logic [12:0] first_cl;
  logic [12:0] prev_cl;
  logic [12:0] cur;
  logic [12:0] found;
  logic [12:0] scan_cnt;
  logic [23:0] n_left;
  logic [31:0] res;
  logic [1:0]  stat;
  logic [12:0] free_total;
  logic [12:0] scan_hint;

  logic        out_valid;
  logic [31:0] out_cluster;
  logic [1:0]  out_status;
  logic [12:0] out_free;
  logic [12:0] out_hint;

  logic [12:0] lim;
  logic [12:0] scan_start;
  logic [12:0] cur_nx;
  logic        scan_last;
  logic        walk_bad;
  logic [32:0] len_sum;
  logic [32:0] len_clusters;
  logic [23:0] n_req;
  logic        accept;

  assign lim = cfg.limit;

  // A hint outside the scan range restarts the scan at the first data cluster.
  assign scan_start = (scan_hint >= FIRST_DATA && scan_hint < lim) ? scan_hint : FIRST_DATA;
  assign cur_nx     = ((cur + 13'd1) >= lim) ? FIRST_DATA : cur + 13'd1;
  assign scan_last  = (scan_cnt + 13'd1) == (lim - FIRST_DATA);
  assign walk_bad   = (walk_c < {19'd0, FIRST_DATA}) || (walk_c >= {19'd0, lim});

  // Cluster count is the byte length rounded up to whole clusters.
  assign len_sum      = {1'b0, req.byte_length} + ((33'd1 << cfg.shift) - 33'd1);
  assign len_clusters = len_sum >> cfg.shift;
  assign n_req        = len_clusters[23:0];

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  assign rsp.valid          = out_valid;
  assign rsp.result_cluster = out_cluster;
  assign rsp.status         = out_status;
  assign rsp.free_count     = out_free;
  assign rsp.next_free_hint = out_hint;

  // Table port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(cur);
    mem_wdata = 32'd0;
    mem_raddr = AW'(cur);
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == AW'(0)) begin
          mem_wdata = MEDIA_MARK;
        end else if (clr_addr == AW'(1)) begin
          mem_wdata = END_MARK;
        end else begin
          mem_wdata = 32'd0;
        end
      end
      S_IDLE:    mem_raddr = req.cluster_number[AW-1:0];
      S_SCAN_RD: mem_raddr = AW'(scan_start);
      S_SCAN_CHK: begin
        if (rdata == 32'd0) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(cur);
          mem_wdata = END_MARK;
        end else begin
          mem_raddr = AW'(cur_nx);
        end
      end
      S_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(prev_cl);
        mem_wdata = {19'd0, found};
      end
      S_WALK_RD: mem_raddr = walk_c[AW-1:0];
      S_WALK_CHK: begin
        mem_waddr = walk_c[AW-1:0];
        mem_we    = (rdata != 32'd0);
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      sweep_reply <= 1'b0;
      ext_mode    <= 1'b0;
      linking     <= 1'b0;
      rollback    <= 1'b0;
      free_total  <= RESET_FREE;
      scan_hint   <= FIRST_DATA;
      out_valid   <= 1'b0;
    end else begin
      // The output register is loaded from the result state, or emptied by a
      // transfer when nothing new is loaded.
      if (state == S_OUT && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            ext_req  <= req.extend;
            ext_mode <= 1'b0;
            linking  <= 1'b0;
            rollback <= 1'b0;
            res      <= 32'd0;
            stat     <= ST_OK;
            case (cmd_t'(req.command))
              CMD_INIT: begin
                free_total  <= lim;
                scan_hint   <= FIRST_DATA;
                clr_addr    <= '0;
                sweep_reply <= 1'b1;
                state       <= S_CLEAR;
              end
              CMD_ALLOC: begin
                n_left <= (n_req == 24'd0) ? 24'd0 : n_req - 24'd1;
                state  <= S_SCAN_RD;
              end
              CMD_FREE: begin
                walk_c <= req.cluster_number;
                state  <= S_WALK_RD;
              end
              default: begin
                prev_cl <= req.cluster_number[12:0];
                if (req.cluster_number == END_MARK ||
                    req.cluster_number >= {19'd0, lim}) begin
                  res   <= END_MARK;
                  state <= S_OUT;
                end else begin
                  state <= S_NEXT_CHK;
                end
              end
            endcase
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            sweep_reply <= 1'b0;
            state       <= sweep_reply ? S_OUT : S_IDLE;
          end
        end
        S_SCAN_RD: begin
          cur      <= scan_start;
          scan_cnt <= 13'd0;
          state    <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (rdata == 32'd0) begin
            found     <= cur;
            scan_hint <= cur_nx;
            if (free_total != 13'd0) begin
              free_total <= free_total - 13'd1;
            end
            if (!ext_mode && !linking) begin
              first_cl <= cur;
              prev_cl  <= cur;
              linking  <= 1'b1;
              if (n_left == 24'd0) begin
                res   <= {19'd0, cur};
                state <= S_OUT;
              end else begin
                state <= S_SCAN_RD;
              end
            end else begin
              state <= S_LINK;
            end
          end else if (scan_last) begin
            // Table full: a partial chain is released, otherwise just report.
            res  <= 32'd0;
            stat <= ST_FULL;
            if (!ext_mode && linking) begin
              rollback <= 1'b1;
              walk_c   <= {19'd0, first_cl};
              state    <= S_WALK_RD;
            end else begin
              state <= S_OUT;
            end
          end else begin
            cur      <= cur_nx;
            scan_cnt <= scan_cnt + 13'd1;
          end
        end
        S_LINK: begin
          if (ext_mode) begin
            res   <= {19'd0, found};
            state <= S_OUT;
          end else begin
            prev_cl <= found;
            n_left  <= n_left - 24'd1;
            if (n_left == 24'd1) begin
              res   <= {19'd0, first_cl};
              state <= S_OUT;
            end else begin
              state <= S_SCAN_RD;
            end
          end
        end
        S_WALK_RD: begin
          if (walk_c == END_MARK) begin
            stat  <= rollback ? ST_FULL : ST_OK;
            state <= S_OUT;
          end else if (walk_bad) begin
            stat  <= rollback ? ST_FULL : ST_BROKEN;
            state <= S_OUT;
          end else begin
            state <= S_WALK_CHK;
          end
        end
        S_WALK_CHK: begin
          if (rdata == 32'd0) begin
            stat  <= rollback ? ST_FULL : ST_BROKEN;
            state <= S_OUT;
          end else begin
            if (free_total != COUNT_MAX) begin
              free_total <= free_total + 13'd1;
            end
            if (walk_c[12:0] < scan_hint) begin
              scan_hint <= walk_c[12:0];
            end
            walk_c <= rdata;
            state  <= S_WALK_RD;
          end
        end
        S_NEXT_CHK: begin
          if (ext_req && rdata == END_MARK && prev_cl >= FIRST_DATA) begin
            ext_mode <= 1'b1;
            state    <= S_SCAN_RD;
          end else begin
            res   <= rdata;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || rsp.ready) begin
            out_cluster <= res;
            out_status  <= stat;
            out_free    <= free_total;
            out_hint    <= scan_hint;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A command transfer always starts work, so the sequencer leaves idle.
  `FCCA_ASSERT_NEXT(a_accept_busy, clk, rst, accept, state != S_IDLE, "accepted command left sequencer idle")
  // A result waiting on a stalled output is not overwritten.
  `FCCA_ASSERT_NEXT(a_out_hold, clk, rst, state == S_OUT && rsp.valid && !rsp.ready, state == S_OUT && rsp.valid, "pending result overwritten")
  // The chain walk only clears entries below the table limit.
  `FCCA_ASSERT(a_walk_range, clk, rst, (state == S_WALK_CHK) |-> (walk_c < {19'd0, lim}), "chain walk outside the table limit")

endmodule
`default_nettype wire
